// File: hdl/math_expression_tokenizer_unit_macros.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef MATH_EXPRESSION_TOKENIZER_UNIT_MACROS_SVH
`define MATH_EXPRESSION_TOKENIZER_UNIT_MACROS_SVH

// Condition and consequence in the same cycle.
`define MTU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define MTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mtu_pkg.sv
package mtu_pkg;

    // Fixed field widths of the token channel
    localparam int TOKEN_START_W  = 16;
    localparam int TOKEN_LENGTH_W = 8;

    // Defaults for the top-level parameters
    localparam int DEF_POSITION_BITS = 16;
    localparam int DEF_LENGTH_BITS   = 8;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Token kinds
    localparam logic [3:0] KIND_VAR    = 4'd0;
    localparam logic [3:0] KIND_FUNC   = 4'd1;
    localparam logic [3:0] KIND_DIGIT  = 4'd2;
    localparam logic [3:0] KIND_MUL    = 4'd3;
    localparam logic [3:0] KIND_POW    = 4'd4;
    localparam logic [3:0] KIND_PLUS   = 4'd5;
    localparam logic [3:0] KIND_MINUS  = 4'd6;
    localparam logic [3:0] KIND_DIV    = 4'd7;
    localparam logic [3:0] KIND_MOD    = 4'd8;
    localparam logic [3:0] KIND_FACT   = 4'd9;
    localparam logic [3:0] KIND_LPAREN = 4'd10;
    localparam logic [3:0] KIND_RPAREN = 4'd11;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL    = 2'd1;
    localparam logic [1:0] ERR_TRIPLE_STAR = 2'd2;
    localparam logic [1:0] ERR_SECOND_DOT = 2'd3;

    // One result beat
    typedef struct packed {
        logic [3:0]                kind;
        logic [TOKEN_START_W-1:0]  start;
        logic [TOKEN_LENGTH_W-1:0] length;
        logic [1:0]                err;
    } tok_t;

    // All results of one character: one or two tokens
    typedef struct packed {
        tok_t first;
        tok_t second;
        logic two;
    } entry_t;

endpackage

// File: hdl/mtu_char_if.sv
interface mtu_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// File: hdl/mtu_tok_if.sv
interface mtu_tok_if;
    import mtu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [3:0]                token_kind;
    logic [TOKEN_START_W-1:0]  token_start;
    logic [TOKEN_LENGTH_W-1:0] token_length;
    logic [1:0]                error_code;
    logic                      last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output error_code, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input error_code, input last_of_run,
                  output ready);
endinterface

// File: hdl/mtu_front.sv
`include "math_expression_tokenizer_unit_macros.svh"

module mtu_front #(
    parameter int POSITION_BITS = mtu_pkg::DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = mtu_pkg::DEF_LENGTH_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    mtu_char_if.sink        char_in,
    input  logic            full,
    output logic            push,
    output mtu_pkg::entry_t push_entry
);
    import mtu_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_STAR,
        MODE_ERR
    } mode_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_FACT   = 8'h21;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [LENGTH_BITS-1:0]   plen_reg, plen_next;
    logic                     dot_reg, dot_next;
    logic [1:0]               star_reg, star_next;

    logic                   accept;
    logic [7:0]             ch;
    logic                   eot;
    logic                   is_letter, is_digit;
    logic                   sym_ok;
    logic [3:0]             sym_kind;
    logic [LENGTH_BITS-1:0] plen_grown;
    logic                   handled;
    logic                   a_v, b_v, c_v;
    tok_t                   a_tok, b_tok, c_tok;

    // Pending run turned into a token beat
    function automatic tok_t run_token(mode_t m, logic [1:0] stars, logic is_func,
                                       logic [POSITION_BITS-1:0] start,
                                       logic [LENGTH_BITS-1:0] len);
        tok_t t;
        t.start  = TOKEN_START_W'(start);
        t.length = TOKEN_LENGTH_W'(len);
        t.err    = ERR_NONE;
        case (m)
            MODE_WORD: t.kind = is_func ? KIND_FUNC : KIND_VAR;
            MODE_NUM:  t.kind = KIND_DIGIT;
            MODE_STAR: t.kind = (stars == 2'd1) ? KIND_MUL : KIND_POW;
            default:   t.kind = KIND_VAR;
        endcase
        return t;
    endfunction

    // Single-character error beat
    function automatic tok_t err_token(logic [1:0] code, logic [POSITION_BITS-1:0] at);
        tok_t t;
        t.kind   = KIND_VAR;
        t.start  = TOKEN_START_W'(at);
        t.length = TOKEN_LENGTH_W'(1);
        t.err    = code;
        return t;
    endfunction

    assign accept         = char_in.valid && char_in.ready;
    assign char_in.ready  = !full;
    assign ch             = char_in.char_code;
    assign eot            = char_in.end_of_text;
    assign is_letter      = (ch inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]});
    assign is_digit       = (ch inside {[CH_ZERO:CH_NINE]});
    assign plen_grown     = (plen_reg == LEN_MAX) ? plen_reg : plen_reg + 1'b1;

    // Single-character operators
    always_comb
    begin
        sym_ok   = 1'b1;
        sym_kind = KIND_VAR;
        case (ch)
            CH_PLUS:   sym_kind = KIND_PLUS;
            CH_MINUS:  sym_kind = KIND_MINUS;
            CH_SLASH:  sym_kind = KIND_DIV;
            CH_MOD:    sym_kind = KIND_MOD;
            CH_FACT:   sym_kind = KIND_FACT;
            CH_LPAREN: sym_kind = KIND_LPAREN;
            CH_RPAREN: sym_kind = KIND_RPAREN;
            default:   sym_ok   = 1'b0;
        endcase
    end

    // Scanner step: next state and up to three candidate beats (at most two fire)
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        dot_next    = dot_reg;
        star_next   = star_reg;
        handled     = 1'b0;
        a_v         = 1'b0;
        b_v         = 1'b0;
        c_v         = 1'b0;
        a_tok       = '0;
        b_tok       = '0;
        c_tok       = '0;

        if (mode_reg == MODE_ERR)
        begin
            // Swallow everything up to the end of the text
            if (eot)
            begin
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                pstart_next = '0;
                plen_next   = '0;
                dot_next    = 1'b0;
                star_next   = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else
        begin
            // Character continues the current run
            if (mode_reg == MODE_WORD && is_letter)
            begin
                handled   = 1'b1;
                plen_next = plen_grown;
            end
            else if (mode_reg == MODE_NUM && (is_digit || ch == CH_DOT))
            begin
                handled = 1'b1;
                if (ch == CH_DOT && dot_reg)
                begin
                    a_v       = 1'b1;
                    a_tok     = err_token(ERR_SECOND_DOT, pos_reg);
                    mode_next = MODE_ERR;
                end
                else
                begin
                    if (ch == CH_DOT)
                    begin
                        dot_next = 1'b1;
                    end
                    plen_next = plen_grown;
                end
            end
            else if (mode_reg == MODE_STAR && ch == CH_STAR)
            begin
                handled = 1'b1;
                if (star_reg >= 2'd2)
                begin
                    a_v       = 1'b1;
                    a_tok     = err_token(ERR_TRIPLE_STAR, pos_reg);
                    mode_next = MODE_ERR;
                end
                else
                begin
                    star_next = star_reg + 2'd1;
                    plen_next = plen_grown;
                end
            end

            // Character ends the run: flush, then classify it on its own
            if (!handled)
            begin
                if (mode_reg == MODE_WORD || mode_reg == MODE_NUM || mode_reg == MODE_STAR)
                begin
                    a_v       = 1'b1;
                    a_tok     = run_token(mode_reg, star_reg, ch == CH_LPAREN,
                                          pstart_reg, plen_reg);
                    mode_next = MODE_IDLE;
                end
                if (ch == CH_SPACE)
                begin
                    // skipped
                end
                else if (is_letter || is_digit || ch == CH_STAR)
                begin
                    mode_next   = is_letter ? MODE_WORD : (is_digit ? MODE_NUM : MODE_STAR);
                    pstart_next = pos_reg;
                    plen_next   = LENGTH_BITS'(1);
                    dot_next    = 1'b0;
                    star_next   = (ch == CH_STAR) ? 2'd1 : 2'd0;
                end
                else if (sym_ok)
                begin
                    b_v          = 1'b1;
                    b_tok.kind   = sym_kind;
                    b_tok.start  = TOKEN_START_W'(pos_reg);
                    b_tok.length = TOKEN_LENGTH_W'(1);
                    b_tok.err    = ERR_NONE;
                end
                else
                begin
                    b_v       = 1'b1;
                    b_tok     = err_token(ERR_ILLEGAL, pos_reg);
                    mode_next = MODE_ERR;
                end
            end

            // End of text: flush what is left and start over at position zero
            if (eot)
            begin
                if (mode_next == MODE_WORD || mode_next == MODE_NUM || mode_next == MODE_STAR)
                begin
                    c_v   = 1'b1;
                    c_tok = run_token(mode_next, star_next, 1'b0, pstart_next, plen_next);
                end
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                pstart_next = '0;
                plen_next   = '0;
                dot_next    = 1'b0;
                star_next   = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Pack the beats of this character into one queue entry
    assign push             = accept && (a_v || b_v || c_v);
    assign push_entry.first = a_v ? a_tok : (b_v ? b_tok : c_tok);
    assign push_entry.second = (a_v && b_v) ? b_tok : c_tok;
    assign push_entry.two   = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            dot_reg    <= 1'b0;
            star_reg   <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            dot_reg    <= dot_next;
            star_reg   <= star_next;
        end
    end

    `MTU_ASSERT_SAME(a_err_quiet, clk, rst_n, mode_reg == MODE_ERR, !push, "beat pushed after an error")
    `MTU_ASSERT_SAME(a_pair_clean, clk, rst_n, push && push_entry.two, push_entry.first.err == ERR_NONE, "error beat followed by another")
    `MTU_ASSERT_NEXT(a_eot_restart, clk, rst_n, accept && eot, pos_reg == '0, "position not cleared after end of text")

endmodule

// File: hdl/mtu_queue.sv
`include "math_expression_tokenizer_unit_macros.svh"

module mtu_queue #(
    parameter int DEPTH = mtu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mtu_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output mtu_pkg::entry_t pop_entry,
    output logic            empty
);
    import mtu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `MTU_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
    `MTU_ASSERT_SAME(a_no_underflow, clk, rst_n, pop, !empty, "pop from an empty queue")

endmodule

// File: hdl/mtu_back.sv
`include "math_expression_tokenizer_unit_macros.svh"

module mtu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  mtu_pkg::entry_t pop_entry,
    output logic            pop,
    mtu_tok_if.source       tok_out
);
    import mtu_pkg::*;

    logic out_valid_reg;
    logic out_last_reg;
    tok_t out_tok_reg;
    logic sec_valid_reg;
    tok_t sec_tok_reg;
    logic out_free;

    // Output register can take a new beat
    assign out_free = !out_valid_reg || tok_out.ready;
    assign pop      = out_free && !sec_valid_reg && !empty;

    assign tok_out.valid        = out_valid_reg;
    assign tok_out.token_kind   = out_tok_reg.kind;
    assign tok_out.token_start  = out_tok_reg.start;
    assign tok_out.token_length = out_tok_reg.length;
    assign tok_out.error_code   = out_tok_reg.err;
    assign tok_out.last_of_run  = out_last_reg;

    // Control: output valid and held second beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (sec_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                sec_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= !empty;
                sec_valid_reg <= !empty && pop_entry.two;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (sec_valid_reg)
            begin
                out_tok_reg  <= sec_tok_reg;
                out_last_reg <= 1'b1;
            end
            else if (!empty)
            begin
                out_tok_reg  <= pop_entry.first;
                out_last_reg <= !pop_entry.two;
                sec_tok_reg  <= pop_entry.second;
            end
        end
    end

    `MTU_ASSERT_NEXT(a_second_follows, clk, rst_n, tok_out.valid && tok_out.ready && !tok_out.last_of_run, tok_out.valid && tok_out.last_of_run, "second beat of a character missing")

endmodule

// File: hdl/math_expression_tokenizer_unit.sv
// Arithmetic expression tokenizer.
// char_in carries one ASCII character per beat, with end_of_text on the last
// character of an expression. tok_out carries tokens as kind, start position
// and length, plus an error code; last_of_run marks the final beat that a
// character produced. A character yields zero, one or two beats.
// Throughput: one character per cycle while the queue is not full. The
// scanner classifies a character and updates its run state in the cycle it
// is accepted; the results go into a small queue of per-character entries.
// The output stage drains one beat per cycle while tok_out is ready, so a
// character that gives two tokens presents them as consecutive beats. On its
// way to tok_out a beat is registered first in the queue and then in the
// output register.
// When tok_out stalls, the output register keeps its beat and the queue
// absorbs up to QUEUE_DEPTH more characters that produce tokens before
// char_in.ready drops.
// After an error the rest of the expression gives no beats; end_of_text
// restarts at position zero. Reset clears the scanner, queue and output.
module math_expression_tokenizer_unit #(
    parameter int POSITION_BITS = mtu_pkg::DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = mtu_pkg::DEF_LENGTH_BITS,
    parameter int QUEUE_DEPTH   = mtu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    mtu_char_if.sink  char_in,
    mtu_tok_if.source tok_out
);
    import mtu_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    entry_t pop_entry;
    logic   empty;

    mtu_front #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    mtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    mtu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_entry (pop_entry),
        .pop       (pop),
        .tok_out   (tok_out)
    );

endmodule
